>>> design/dcvp_pkg.sv
// shared constants and types for the deck code varint parser
`default_nettype none

package dcvp_pkg;

  // longest varint accepted, in bytes (1 to 10)
  localparam int unsigned MAX_VARINT_BYTES = 5;
  // byte counter width, holds 0 .. MAX_VARINT_BYTES
  localparam int unsigned IDX_W = $clog2(MAX_VARINT_BYTES + 1);
  // shift amount width, covers 7 * (MAX_VARINT_BYTES - 1)
  localparam int unsigned SHIFT_W = 6;

  localparam int unsigned ID_W = 32;
  localparam int unsigned COPIES_W = 8;
  localparam int unsigned STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_CARD     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_VERSION  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LONG     = 3'd5;

  localparam logic [COPIES_W-1:0] COPIES_MAX = 8'd255;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_VERSION,
    PH_FORMAT,
    PH_NHERO,
    PH_HERO,
    PH_N1,
    PH_C1,
    PH_N2,
    PH_C2,
    PH_NN,
    PH_NID,
    PH_NCNT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [ID_W-1:0]     card_id;
    logic [COPIES_W-1:0] copies;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

>>> design/dcvp_in_if.sv
// byte channel into the deck code varint parser
`default_nettype none

interface dcvp_in_if import dcvp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       final_byte;

  modport source(output valid, output data_byte, output first_byte, output final_byte,
                 input ready);
  modport sink(input valid, input data_byte, input first_byte, input final_byte,
               output ready);
endinterface

`default_nettype wire

>>> design/dcvp_out_if.sv
// result channel out of the deck code varint parser
`default_nettype none

interface dcvp_out_if import dcvp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     card_id;
  logic [COPIES_W-1:0] copies;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source(output valid, output card_id, output copies, output status, output last,
                 input ready);
  modport sink(input valid, input card_id, input copies, input status, input last,
               output ready);
endinterface

`default_nettype wire

>>> design/deck_code_varint_parser.sv
// deck code varint parser: header checks, section walk and result queue
// a result is registered into the result queue when the byte that causes it is accepted
// throughput: one byte per cycle; a byte that yields two results holds the
// four-entry result queue one extra slot, so input pauses only when the sink stalls
// reset: synchronous, active high; parser goes idle, queue empties,
// expected_version returns to 1
`default_nettype none

module deck_code_varint_parser import dcvp_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_wr_en,
  input  wire  [7:0] cfg_wr_data,
  dcvp_in_if.sink    bytes,
  dcvp_out_if.source results
);

  // configuration
  logic [7:0] expected_version;

  // parser state
  phase_t          phase, phase_next;
  logic [31:0]     accumulator, accumulator_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [31:0]     entries_left, entries_left_next;
  logic [31:0]     pending_id, pending_id_next;

  // result queue
  result_t          fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  logic in_acc, out_acc;

  // results from the byte in flight
  logic          card_v, term_v;
  logic [31:0]   card_id_c;
  logic [7:0]    card_cp;
  logic [STATUS_W-1:0] term_st;

  // varint assembly
  logic [SHIFT_W-1:0] shamt;
  logic [63:0]        shifted;
  logic [31:0]        acc_v;
  logic [IDX_W-1:0]   idx_inc;
  logic [31:0]        ent_dec;
  logic               active;

  // room for two results keeps the worst-case byte safe without looking at the payload
  assign bytes.ready = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign in_acc      = bytes.valid && bytes.ready;
  assign out_acc     = results.valid && results.ready;

  // payload bits past bit 31 fall off the top of the 32-bit value
  assign shamt   = SHIFT_W'(byte_index) * SHIFT_W'(7);
  assign shifted = {57'd0, bytes.data_byte[6:0]} << shamt;
  assign acc_v   = accumulator | shifted[31:0];
  assign idx_inc = byte_index + IDX_W'(1);
  assign ent_dec = entries_left - 32'd1;

  always_comb begin
    phase_next        = phase;
    accumulator_next  = accumulator;
    byte_index_next   = byte_index;
    entries_left_next = entries_left;
    pending_id_next   = pending_id;
    card_v    = 1'b0;
    card_id_c = '0;
    card_cp   = '0;
    term_v    = 1'b0;
    term_st   = ST_COMPLETE;
    active    = 1'b1;

    if (bytes.first_byte) begin
      // restart: this byte is the reserved byte
      accumulator_next  = '0;
      byte_index_next   = '0;
      entries_left_next = '0;
      pending_id_next   = '0;
      if (bytes.data_byte != 8'd0) begin
        term_v     = 1'b1;
        term_st    = ST_RESERVED;
        phase_next = PH_DONE;
      end else begin
        phase_next = PH_VERSION;
      end
    end else if (phase == PH_IDLE || phase == PH_DONE) begin
      // nothing to parse, byte dropped
      active = 1'b0;
    end else if (bytes.data_byte[7]) begin
      // continuation byte
      if (idx_inc >= IDX_W'(MAX_VARINT_BYTES)) begin
        term_v          = 1'b1;
        term_st         = ST_LONG;
        phase_next      = PH_DONE;
        accumulator_next = '0;
        byte_index_next = '0;
      end else begin
        accumulator_next = acc_v;
        byte_index_next  = idx_inc;
      end
    end else begin
      // varint complete, acc_v is the value
      accumulator_next = '0;
      byte_index_next  = '0;
      case (phase)
        PH_VERSION: begin
          if (acc_v != {24'd0, expected_version}) begin
            term_v     = 1'b1;
            term_st    = ST_VERSION;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_FORMAT;
          end
        end
        PH_FORMAT: phase_next = PH_NHERO;
        PH_NHERO: begin
          entries_left_next = acc_v;
          phase_next = (acc_v != 32'd0) ? PH_HERO : PH_N1;
        end
        PH_HERO: begin
          entries_left_next = ent_dec;
          if (ent_dec == 32'd0) phase_next = PH_N1;
        end
        PH_N1: begin
          entries_left_next = acc_v;
          phase_next = (acc_v != 32'd0) ? PH_C1 : PH_N2;
        end
        PH_C1: begin
          card_v    = 1'b1;
          card_id_c = acc_v;
          card_cp   = 8'd1;
          entries_left_next = ent_dec;
          if (ent_dec == 32'd0) phase_next = PH_N2;
        end
        PH_N2: begin
          entries_left_next = acc_v;
          phase_next = (acc_v != 32'd0) ? PH_C2 : PH_NN;
        end
        PH_C2: begin
          card_v    = 1'b1;
          card_id_c = acc_v;
          card_cp   = 8'd2;
          entries_left_next = ent_dec;
          if (ent_dec == 32'd0) phase_next = PH_NN;
        end
        PH_NN: begin
          entries_left_next = acc_v;
          if (acc_v != 32'd0) begin
            phase_next = PH_NID;
          end else begin
            term_v     = 1'b1;
            term_st    = ST_COMPLETE;
            phase_next = PH_DONE;
          end
        end
        PH_NID: begin
          pending_id_next = acc_v;
          phase_next      = PH_NCNT;
        end
        PH_NCNT: begin
          card_v    = 1'b1;
          card_id_c = pending_id;
          // count saturates at 255
          card_cp   = (acc_v > 32'd255) ? COPIES_MAX : acc_v[7:0];
          entries_left_next = ent_dec;
          if (ent_dec == 32'd0) begin
            term_v     = 1'b1;
            term_st    = ST_COMPLETE;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_NID;
          end
        end
        default: begin
        end
      endcase
    end

    // string ended before the deck was complete
    if (active && bytes.final_byte && phase_next != PH_DONE) begin
      term_v     = 1'b1;
      term_st    = ST_TRUNC;
      phase_next = PH_DONE;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 8'd1;
    end else if (cfg_wr_en) begin
      expected_version <= cfg_wr_data;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      accumulator  <= '0;
      byte_index   <= '0;
      entries_left <= '0;
      pending_id   <= '0;
    end else if (in_acc) begin
      phase        <= phase_next;
      accumulator  <= accumulator_next;
      byte_index   <= byte_index_next;
      entries_left <= entries_left_next;
      pending_id   <= pending_id_next;
    end
  end

  // result queue: card result goes in first, terminal result after it
  result_t          slot0, slot1;
  logic [1:0]       push_n;
  logic [PTR_W-1:0] wr_ptr1;

  assign slot0   = card_v ? result_t'{card_id_c, card_cp, ST_CARD, 1'b0}
                          : result_t'{32'd0, 8'd0, term_st, 1'b1};
  assign slot1   = result_t'{32'd0, 8'd0, term_st, 1'b1};
  assign push_n  = in_acc ? ({1'b0, card_v} + {1'b0, term_v}) : 2'd0;
  assign wr_ptr1 = wr_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= slot0;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr1] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (out_acc) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(push_n) - CNT_W'(out_acc);
    end
  end

  assign results.valid   = (count != '0);
  assign results.card_id = fifo[rd_ptr].card_id;
  assign results.copies  = fifo[rd_ptr].copies;
  assign results.status  = fifo[rd_ptr].status;
  assign results.last    = fifo[rd_ptr].last;

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // last marks exactly the terminal results
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.last == (results.status != ST_CARD)))
    else $error("last flag disagrees with status");

  // a finished parse adds nothing until restarted
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !bytes.first_byte && phase == PH_DONE) |=> count <= $past(count))
    else $error("result after parse end");

  // status codes stay in range at the port
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.status <= ST_LONG)
    else $error("status code out of range");

endmodule

`default_nettype wire
